FILE: src/sfp_pkg.sv
`timescale 1ns / 1ps

package sfp_pkg;

    // frame geometry: header, body bytes held in the cell row, trailer
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned COUNT_W       = 4;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_END_MARKER  = 2'd2;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hFF;
    localparam logic [7:0] END_MARKER_RST  = 8'hFF;

    // hunt phases of the frame sequencer
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    // strobes from the sequencer to the cell row and output stage
    typedef struct packed {
        logic shift;
        logic emit;
        logic ok;
    } t_ctrl;

endpackage

FILE: src/sfp_cell.sv
`timescale 1ns / 1ps

module sfp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_data,
    output logic [7:0] o_data
);

    logic [7:0] r_data;

    // hold one body byte, pass it on to the neighbour on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: src/sfp_ctrl.sv
`timescale 1ns / 1ps

module sfp_ctrl
    import sfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_sync_first,
    input  logic [7:0] i_sync_second,
    input  logic [7:0] i_end_marker,
    output t_ctrl      o_ctrl
);

    t_phase             r_phase;
    t_phase             n_phase;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               body_full;

    assign body_full = (r_count >= COUNT_W'(PAYLOAD_BYTES));

    // next phase and body count
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_take) begin
            unique case (r_phase)
                PH_SECOND: begin
                    if (i_rx_byte == i_sync_second) begin
                        n_phase = PH_BODY;
                        n_count = '0;
                    end else begin
                        n_phase = PH_FIRST;
                    end
                end
                PH_BODY: begin
                    if (!body_full) begin
                        n_count = r_count + COUNT_W'(1);
                    end else begin
                        n_phase = PH_FIRST;
                        n_count = '0;
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == i_sync_first) ? PH_SECOND : PH_FIRST;
                end
            endcase
        end
    end

    // strobes for the cell row and the output stage
    always_comb begin
        o_ctrl = '0;
        if (i_take && r_phase == PH_BODY) begin
            o_ctrl.shift = !body_full;
            o_ctrl.emit  = body_full;
            o_ctrl.ok    = body_full && (i_rx_byte == i_end_marker);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

FILE: src/sync_header_frame_parser.sv
`timescale 1ns / 1ps

// Sync-header frame parser.
// Input channel: one received byte per item (i_rx_valid / o_rx_ready).
// The block hunts for the two header bytes, collects eight body bytes in a
// row of byte cells that shift once per body byte, then checks the trailer.
// Output channel (o_res_valid / i_res_ready): one item per frame, with
// o_frame_ok set and body bytes 2 to 9 when the trailer matches the end
// marker, or all zeros with o_frame_ok clear when it does not.
// Throughput is one byte per cycle while o_rx_ready is high; every byte is
// handled in the cycle it is accepted, and a frame result appears in the
// output register in the cycle after its trailer byte is taken.
// The output register lets bytes keep flowing while a result waits; only
// when a result is held and i_res_ready is low does o_rx_ready drop.
// Configuration: APB-style registers sync_first (0x0), sync_second (0x4)
// and end_marker (0x8); the user writes them only while idle (unenforced).
// Reset (synchronous, active low) returns to hunting, empties the output
// register and restores register defaults 0xAA, 0xFF and 0xFF.

module sync_header_frame_parser
    import sfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_frame_ok,
    output logic [7:0]  o_length_field,
    output logic [7:0]  o_command,
    output logic [7:0]  o_field_four,
    output logic [7:0]  o_field_five,
    output logic [7:0]  o_field_six,
    output logic [7:0]  o_field_seven,
    output logic [7:0]  o_field_eight,
    output logic [7:0]  o_field_nine
);

    logic [7:0] r_sync_first;
    logic [7:0] r_sync_second;
    logic [7:0] r_end_marker;
    logic [1:0] reg_idx;
    logic       take;
    t_ctrl      ctrl;
    logic [7:0] cell_data [PAYLOAD_BYTES+1];
    logic       r_res_valid;
    logic       r_frame_ok;
    logic [7:0] r_field [PAYLOAD_BYTES];

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_end_marker  <= END_MARKER_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_SYNC_FIRST:  r_sync_first  <= pwdata[7:0];
                REG_SYNC_SECOND: r_sync_second <= pwdata[7:0];
                REG_END_MARKER:  r_end_marker  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SYNC_FIRST:  prdata = {24'd0, r_sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_sync_second};
            REG_END_MARKER:  prdata = {24'd0, r_end_marker};
            default:         prdata = '0;
        endcase
    end

    // input handshake, held off only by a waiting result
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign take       = i_rx_valid && o_rx_ready;

    sfp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_rx_byte     (i_rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .i_end_marker  (r_end_marker),
        .o_ctrl        (ctrl)
    );

    // row of byte cells, new bytes enter at the top end
    assign cell_data[PAYLOAD_BYTES] = i_rx_byte;

    for (genvar k = 0; k < PAYLOAD_BYTES; k++) begin : g_cell
        sfp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (ctrl.shift),
            .i_data  (cell_data[k+1]),
            .o_data  (cell_data[k])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_frame_ok <= ctrl.ok;
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                r_field[k] <= ctrl.ok ? cell_data[k] : 8'd0;
            end
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_frame_ok     = r_frame_ok;
    assign o_length_field = r_field[0];
    assign o_command      = r_field[1];
    assign o_field_four   = r_field[2];
    assign o_field_five   = r_field[3];
    assign o_field_six    = r_field[4];
    assign o_field_seven  = r_field[5];
    assign o_field_eight  = r_field[6];
    assign o_field_nine   = r_field[7];

endmodule

FILE: bench/tb_sync_header_frame_parser.sv
`timescale 1ns / 1ps

module tb_sync_header_frame_parser;
    import sfp_pkg::*;

    // one frame result as it leaves the block, body[0] is frame byte 2
    typedef struct packed {
        logic            ok;
        logic [0:7][7:0] body;
    } t_frame;

    // one row of the directed part: a byte and, where obvious, its frame result
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_frame     want;
    } t_row;

    localparam int N_ROWS     = 25;
    localparam int N_SETTINGS = 8;
    localparam int FRAMES_PER = 7;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_rx_valid;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte;
    logic        o_res_valid;
    logic        i_res_ready;
    logic        o_frame_ok;
    logic [7:0]  o_length_field;
    logic [7:0]  o_command;
    logic [7:0]  o_field_four;
    logic [7:0]  o_field_five;
    logic [7:0]  o_field_six;
    logic [7:0]  o_field_seven;
    logic [7:0]  o_field_eight;
    logic [7:0]  o_field_nine;

    sync_header_frame_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_rx_valid     (i_rx_valid),
        .o_rx_ready     (o_rx_ready),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_frame_ok     (o_frame_ok),
        .o_length_field (o_length_field),
        .o_command      (o_command),
        .o_field_four   (o_field_four),
        .o_field_five   (o_field_five),
        .o_field_six    (o_field_six),
        .o_field_seven  (o_field_seven),
        .o_field_eight  (o_field_eight),
        .o_field_nine   (o_field_nine)
    );

    // deframer mirror: configuration and hunt state
    logic [7:0]         cfg_first;
    logic [7:0]         cfg_second;
    logic [7:0]         cfg_end;
    t_phase             hunt;
    logic [COUNT_W-1:0] held;
    logic [0:7][7:0]    store;

    t_frame frames_due[$];
    t_row   dir_rows[N_ROWS];
    int     n_errors;
    int     n_good;
    int     n_bad;
    int     n_bytes;
    bit     no_gaps;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // predict the effect of one accepted byte
    task automatic deframe_byte(input logic [7:0] b, output bit emits, output t_frame res);
        emits = 1'b0;
        res   = '0;
        case (hunt)
            PH_SECOND: begin
                if (b == cfg_second) begin
                    hunt = PH_BODY;
                    held = '0;
                end else begin
                    hunt = PH_FIRST;
                end
            end
            PH_BODY: begin
                if (held < PAYLOAD_BYTES) begin
                    store[held[2:0]] = b;
                    held = held + 1'b1;
                end else begin
                    // trailer byte closes the frame either way
                    emits = 1'b1;
                    if (b == cfg_end) begin
                        res.ok   = 1'b1;
                        res.body = store;
                    end else begin
                        store = '0;
                    end
                    hunt = PH_FIRST;
                    held = '0;
                end
            end
            default: begin
                hunt = (b == cfg_first) ? PH_SECOND : PH_FIRST;
            end
        endcase
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // offer one item, wait for it to be taken, then record what it should cause
    task automatic send_byte(input logic [7:0] b, input logic typed, input t_frame want);
        int unsigned gap;
        bit          emits;
        t_frame      res;
        gap = pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        n_bytes++;
        deframe_byte(b, emits, res);
        if (typed)
            frames_due.push_back(want);
        else if (emits)
            frames_due.push_back(res);
    endtask

    // register write: setup then access, only while the block is idle
    task automatic reg_write(input logic [1:0] idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  cfg_first  = v;
            REG_SYNC_SECOND: cfg_second = v;
            REG_END_MARKER:  cfg_end    = v;
            default: ;
        endcase
        // bus idle before the next transfer
        @(posedge i_clk);
    endtask

    // mostly well-formed frames, with noise, broken headers and bad trailers mixed in
    task automatic run_traffic(input int n_frames);
        int unsigned r;
        logic [7:0]  b;
        for (int f = 0; f < n_frames; f++) begin
            r = $urandom_range(0, 99);
            if (f == n_frames / 2 && !no_gaps) begin
                // hold off until the output side has drained
                i_rx_valid <= 1'b0;
                wait (frames_due.size() == 0);
                @(posedge i_clk);
            end
            if (r < 12) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, '0);
            end else if (r < 20) begin
                b = 8'($urandom);
                if (b == cfg_second)
                    b = ~b;
                send_byte(cfg_first, 1'b0, '0);
                send_byte(b, 1'b0, '0);
            end
            send_byte(cfg_first, 1'b0, '0);
            send_byte(cfg_second, 1'b0, '0);
            for (int k = 0; k < PAYLOAD_BYTES; k++)
                send_byte(rand_byte(), 1'b0, '0);
            b = ($urandom_range(0, 99) < 70) ? cfg_end : 8'($urandom);
            send_byte(b, 1'b0, '0);
        end
        i_rx_valid <= 1'b0;
    endtask

    // drain, then let the block settle before touching registers
    task automatic wait_idle();
        wait (frames_due.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result side: random stalls, mostly short, sometimes long or absent
    initial begin : res_ready_gen
        int unsigned run;
        int unsigned stall;
        int unsigned r;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            r   = $urandom_range(0, 99);
            run = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 6);
            i_res_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            r     = $urandom_range(0, 99);
            stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (frames_due.size() == 0) begin
                $display("%0t: result with nothing outstanding, frame_ok %b",
                         $time, o_frame_ok);
                n_errors++;
            end else begin
                want = frames_due.pop_front();
                if (o_frame_ok !== want.ok) begin
                    $display("%0t: frame_ok mismatch, expected %b, got %b",
                             $time, want.ok, o_frame_ok);
                    n_errors++;
                end
                cmp_field("length_field", want.body[0], o_length_field);
                cmp_field("command", want.body[1], o_command);
                cmp_field("field_four", want.body[2], o_field_four);
                cmp_field("field_five", want.body[3], o_field_five);
                cmp_field("field_six", want.body[4], o_field_six);
                cmp_field("field_seven", want.body[5], o_field_seven);
                cmp_field("field_eight", want.body[6], o_field_eight);
                cmp_field("field_nine", want.body[7], o_field_nine);
                if (want.ok)
                    n_good++;
                else
                    n_bad++;
            end
        end
    end

    // main sequence
    initial begin : stimulus
        logic [7:0] set_first  [N_SETTINGS];
        logic [7:0] set_second [N_SETTINGS];
        logic [7:0] set_end    [N_SETTINGS];
        t_frame     good;

        i_rst_n     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_res_ready = 1'b0;
        n_errors    = 0;
        n_good      = 0;
        n_bad       = 0;
        n_bytes     = 0;
        no_gaps     = 1'b0;

        cfg_first  = SYNC_FIRST_RST;
        cfg_second = SYNC_SECOND_RST;
        cfg_end    = END_MARKER_RST;
        hunt       = PH_FIRST;
        held       = '0;
        store      = '0;

        // good frame with extreme body bytes, broken header, trailer mismatch
        good.ok   = 1'b1;
        good.body = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA};
        dir_rows[0]  = {8'hAA, 1'b0, 65'd0};
        dir_rows[1]  = {8'hFF, 1'b0, 65'd0};
        for (int k = 0; k < 8; k++)
            dir_rows[2 + k] = {good.body[k], 1'b0, 65'd0};
        dir_rows[10] = {8'hFF, 1'b1, good};
        dir_rows[11] = {8'hAA, 1'b0, 65'd0};
        dir_rows[12] = {8'hAA, 1'b0, 65'd0};
        dir_rows[13] = {8'hFF, 1'b0, 65'd0};
        dir_rows[14] = {8'hAA, 1'b0, 65'd0};
        dir_rows[15] = {8'hFF, 1'b0, 65'd0};
        for (int k = 0; k < 8; k++)
            dir_rows[16 + k] = {8'(8'h11 * (k + 1)), 1'b0, 65'd0};
        dir_rows[24] = {8'h00, 1'b1, 65'd0};

        // register settings: defaults, extremes, equal header bytes, random
        set_first  = '{8'hAA, 8'h00, 8'hFF, 8'h3C, 8'h00, 8'hFF, 8'h00, 8'h00};
        set_second = '{8'hFF, 8'h00, 8'hFF, 8'h3C, 8'hFF, 8'h00, 8'h00, 8'h00};
        set_end    = '{8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h80, 8'h00, 8'h00, 8'h00};
        for (int s = 6; s < N_SETTINGS; s++) begin
            set_first[s]  = 8'($urandom);
            set_second[s] = 8'($urandom);
            set_end[s]    = 8'($urandom);
        end

        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under reset register values
        for (int i = 0; i < N_ROWS; i++)
            send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
        i_rx_valid <= 1'b0;

        // random part, one block of frames per register setting
        for (int s = 0; s < N_SETTINGS; s++) begin
            wait_idle();
            reg_write(REG_SYNC_FIRST, set_first[s]);
            reg_write(REG_SYNC_SECOND, set_second[s]);
            reg_write(REG_END_MARKER, set_end[s]);
            no_gaps = (s == 2);
            @(posedge i_clk);
            run_traffic(FRAMES_PER);
        end

        wait (frames_due.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("%0d bytes sent over %0d register settings", n_bytes, N_SETTINGS + 1);
        $display("%0d good frames and %0d trailer failures checked", n_good, n_bad);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/sfp_pkg.sv
src/sfp_cell.sv
src/sfp_ctrl.sv
src/sync_header_frame_parser.sv
bench/tb_sync_header_frame_parser.sv
